// ----- sv/sse_pkg.sv -----
`timescale 1ns / 1ps
package sse_pkg;

  localparam int StackDepth = 16;
  localparam int NumVars    = 4;
  localparam int SpW        = $clog2(StackDepth);
  localparam int CntW       = $clog2(StackDepth + 1);

  typedef enum logic [3:0] {
    OP_RET  = 4'd0,  OP_LDX = 4'd1,  OP_STX = 4'd2,  OP_LDA = 4'd3,
    OP_STA  = 4'd4,  OP_LDB = 4'd5,  OP_STB = 4'd6,  OP_ADD = 4'd7,
    OP_SUB  = 4'd8,  OP_NEG = 4'd9,  OP_MUL = 4'd10, OP_SQR = 4'd11,
    OP_SQRT = 4'd12, OP_NUM = 4'd13, OP_DUP = 4'd14, OP_ILL = 4'd15
  } op_e;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_ILLEGAL = 2'd1, ST_UNDER = 2'd2, ST_OVER = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE, S_RD2, S_EXEC, S_MUL, S_SQRT, S_OUT
  } state_e;

  typedef struct packed {
    logic [3:0]        op;
    logic [1:0]        var_index;
    logic signed [31:0] immediate;
  } in_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_t;

  // Saturate a 34-bit signed sum to 32 bits.
  function automatic logic [31:0] sat34(input logic signed [33:0] v);
    if (v > 34'sh07FFFFFFF) return 32'h7FFFFFFF;
    if (v < -34'sh080000000) return 32'h80000000;
    return v[31:0];
  endfunction

endpackage

// ----- sv/sse_sqrt.sv -----
`timescale 1ns / 1ps
// Restoring square root of |x|<<16 into a 24-bit root, one result bit per cycle.
module sse_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] x_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import sse_pkg::*;

  logic [47:0] rem_q, rem_d;
  logic [23:0] root_q, root_d;
  logic [47:0] n_q, n_d;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic [32:0] mag;
  logic [47:0] trial, shifted;

  assign mag = x_i[31] ? (33'd0 - {1'b1, x_i}) : {1'b0, x_i};
  assign shifted = {rem_q[45:0], n_q[47:46]};
  assign trial = {root_q, 2'b01};

  // One iteration per cycle
  always_comb begin
    rem_d = rem_q; root_d = root_q; n_d = n_q; cnt_d = cnt_q; busy_d = busy_q;
    if (start_i) begin
      rem_d = '0; root_d = '0; n_d = {mag[31:0], 16'd0}; cnt_d = 5'd24;
      busy_d = 1'b1;
    end else if (busy_q) begin
      n_d = {n_q[45:0], 2'b00};
      if (shifted >= trial) begin
        rem_d = shifted - trial; root_d = {root_q[22:0], 1'b1};
      end else begin
        rem_d = shifted; root_d = {root_q[22:0], 1'b0};
      end
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; root_q <= root_d; n_q <= n_d;
  end

  // mag<<16 < 2^48 so the root fits in 24 bits
  assign done_o = busy_q && (cnt_q == 5'd1);
  assign root_o = {8'd0, root_d};

endmodule

// ----- sv/scalar_stack_evaluator.sv -----
`timescale 1ns / 1ps
// Stack-machine evaluator for Q16.16 expressions. One instruction is taken per
// transfer on the input channel; ret and error cases give one result transfer.
// The operand stack is a synchronous RAM with registered reads: push-only and
// one-operand ops go through S_EXEC, two-operand ops through S_RD2 and S_EXEC,
// sqr and mul on through S_MUL and S_OUT (two 32x16 partial products formed
// together and registered, then summed and written in S_OUT) and sqrt through
// S_SQRT (bit-serial root unit, 24 iterations). Errors are found at accept and
// their result is presented the next cycle. A result waits in an output register;
// the next instruction is taken the cycle after that result is handed over.
module scalar_stack_evaluator (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  sse_pkg::in_t         in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output sse_pkg::out_t        out_data_o
);
  import sse_pkg::*;

  logic [31:0] stack_mem [StackDepth];
  logic [31:0] vars_q [NumVars];
  logic [31:0] rd_q, y_q, scr_a_q, scr_b_q;
  logic [CntW-1:0] cnt_q, cnt_d;
  state_e state_q, state_d;
  in_t ins_q;
  out_t out_q, out_d;
  logic out_v_q, out_v_d;

  logic        rd_en;
  logic [SpW-1:0] rd_addr;
  logic        wr_en, wr_en2;
  logic [SpW-1:0] wr_addr;
  logic [31:0] wr_data;
  logic        y_ld;
  logic        mul_go;
  logic [63:0] plo_q, phi_q;
  logic        mstep_q;
  logic        sq_start, sq_done;
  logic [31:0] sq_root;
  logic        ld_ins;
  logic [1:0]  need;
  logic        pushes;
  logic [31:0] var_rd;
  logic        var_wr, scra_wr, scrb_wr;
  logic [63:0] prod;
  logic [47:0] qv;
  logic [31:0] mul_res;

  assign in_stall_o = (state_q != S_IDLE) || out_v_q;
  assign ld_ins = in_valid_i && !in_stall_o;

  always_comb begin
    need = 2'd0; pushes = 1'b0;
    case (op_e'(in_data_i.op))
      OP_RET, OP_STX, OP_STA, OP_STB, OP_NEG, OP_SQR, OP_SQRT: need = 2'd1;
      OP_ADD, OP_SUB, OP_MUL: need = 2'd2;
      OP_DUP: begin need = 2'd1; pushes = 1'b1; end
      default: pushes = 1'b1;
    endcase
  end

  assign var_rd = (ins_q.var_index < NumVars) ? vars_q[ins_q.var_index] : '0;

  // Signed product from two 32x16 partials
  assign prod = phi_q + plo_q;
  assign qv = prod[63:16];
  assign mul_res = ($signed(qv) > 48'sh00007FFFFFFF) ? 32'h7FFFFFFF :
                   ($signed(qv) < -48'sh000080000000) ? 32'h80000000 : qv[31:0];

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; out_d = out_q; out_v_d = out_v_q;
    rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_en2 = 1'b0; wr_addr = '0;
    wr_data = '0; y_ld = 1'b0; mul_go = 1'b0; sq_start = 1'b0;
    var_wr = 1'b0; scra_wr = 1'b0; scrb_wr = 1'b0;
    if (out_v_q && !out_stall_i) out_v_d = 1'b0;
    case (state_q)
      S_IDLE: if (ld_ins) begin
        if (in_data_i.op == OP_ILL) begin
          cnt_d = '0; out_d = '{value: '0, status: ST_ILLEGAL}; out_v_d = 1'b1;
        end else if (cnt_q < CntW'(need)) begin
          cnt_d = '0; out_d = '{value: '0, status: ST_UNDER}; out_v_d = 1'b1;
        end else if (pushes && cnt_q >= CntW'(StackDepth)) begin
          cnt_d = '0; out_d = '{value: '0, status: ST_OVER}; out_v_d = 1'b1;
        end else begin
          rd_en = 1'b1; rd_addr = SpW'(cnt_q - CntW'(1));
          state_d = (need == 2'd2) ? S_RD2 : S_EXEC;
        end
      end
      S_RD2: begin
        y_ld = 1'b1; rd_en = 1'b1; rd_addr = SpW'(cnt_q - CntW'(2));
        state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (op_e'(ins_q.op))
          OP_RET: begin
            cnt_d = '0; out_d = '{value: rd_q, status: ST_OK}; out_v_d = 1'b1;
          end
          OP_LDX, OP_LDA, OP_LDB, OP_NUM: begin
            wr_en = 1'b1; wr_addr = SpW'(cnt_q); cnt_d = cnt_q + CntW'(1);
            wr_data = (ins_q.op == OP_LDX) ? var_rd :
                      (ins_q.op == OP_LDA) ? scr_a_q :
                      (ins_q.op == OP_LDB) ? scr_b_q : ins_q.immediate;
          end
          OP_STX: begin var_wr = 1'b1; cnt_d = cnt_q - CntW'(1); end
          OP_STA: begin scra_wr = 1'b1; cnt_d = cnt_q - CntW'(1); end
          OP_STB: begin scrb_wr = 1'b1; cnt_d = cnt_q - CntW'(1); end
          OP_ADD, OP_SUB: begin
            wr_en = 1'b1; wr_addr = SpW'(cnt_q - CntW'(2)); cnt_d = cnt_q - CntW'(1);
            wr_data = (ins_q.op == OP_ADD) ?
              sat34({{2{rd_q[31]}}, rd_q} + {{2{y_q[31]}}, y_q}) :
              sat34({{2{rd_q[31]}}, rd_q} - {{2{y_q[31]}}, y_q});
          end
          OP_NEG: begin
            wr_en = 1'b1; wr_addr = SpW'(cnt_q - CntW'(1));
            wr_data = sat34(34'sd0 - {{2{rd_q[31]}}, rd_q});
          end
          OP_MUL, OP_SQR: begin mul_go = 1'b1; state_d = S_MUL; end
          OP_SQRT: begin sq_start = 1'b1; state_d = S_SQRT; end
          OP_DUP: begin
            wr_en = 1'b1; wr_addr = SpW'(cnt_q); wr_data = rd_q;
            cnt_d = cnt_q + CntW'(1);
          end
          default: ;
        endcase
      end
      S_MUL: if (mstep_q) begin
        state_d = S_OUT;
      end
      S_OUT: begin
        wr_en2 = 1'b1; state_d = S_IDLE;
        wr_addr = (ins_q.op == OP_MUL) ? SpW'(cnt_q - CntW'(2)) : SpW'(cnt_q - CntW'(1));
        wr_data = mul_res;
        if (ins_q.op == OP_MUL) cnt_d = cnt_q - CntW'(1);
      end
      S_SQRT: if (sq_done) begin
        wr_en = 1'b1; wr_addr = SpW'(cnt_q - CntW'(1)); wr_data = sq_root;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Stack RAM: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_en || wr_en2) stack_mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= stack_mem[rd_addr];
    if (y_ld) y_q <= rd_q;
    if (ld_ins) ins_q <= in_data_i;
    out_q <= out_d;
  end

  // Multiplier: x * y[15:0] unsigned low half and x * y[31:16] signed, same cycle
  logic [31:0] mx, my;
  logic signed [48:0] pl_w;
  logic signed [47:0] ph_w;
  assign mx = rd_q;
  assign my = (ins_q.op == OP_SQR) ? rd_q : y_q;
  assign pl_w = $signed(mx) * $signed({1'b0, my[15:0]});
  assign ph_w = $signed(mx) * $signed(my[31:16]);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mstep_q <= 1'b0;
    end else begin
      mstep_q <= mul_go;
    end
  end
  always_ff @(posedge clk_i) begin
    if (mul_go) begin
      plo_q <= {{15{pl_w[48]}}, pl_w};
      phi_q <= {{16{ph_w[47]}}, ph_w} << 16;
    end
  end

  sse_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .x_i     (rd_q),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  // Control and architectural registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE; cnt_q <= '0; out_v_q <= 1'b0;
      scr_a_q <= '0; scr_b_q <= '0;
      for (int i = 0; i < NumVars; i++) vars_q[i] <= '0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; out_v_q <= out_v_d;
      if (scra_wr) scr_a_q <= rd_q;
      if (scrb_wr) scr_b_q <= rd_q;
      if (var_wr && ins_q.var_index < NumVars) vars_q[ins_q.var_index] <= rd_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Stack count never exceeds the depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(StackDepth)) else $error("stack count out of range");
  // An instruction is taken only with no pending result
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ld_ins |-> !out_v_q && state_q == S_IDLE) else $error("accept while busy");
  // Root unit finishes before the machine leaves the sqrt state
  a_sqrt_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_done |-> state_q == S_SQRT) else $error("stray root done");

endmodule

// ----- tb/tb_scalar_stack_evaluator.sv -----
`timescale 1ns / 1ps
module tb_scalar_stack_evaluator;
  import sse_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_t out_data_o;

  always #5 clk_i = ~clk_i;

  scalar_stack_evaluator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o)
  );

  // Shadow machine state
  logic [31:0] shadow_stack [StackDepth];
  int unsigned shadow_depth;
  logic [31:0] shadow_a, shadow_b;
  logic [31:0] shadow_vars [NumVars];

  in_t  pending_instr [$];
  out_t expected_results [$];
  int   error_count = 0;
  int   results_seen = 0;
  int   instr_sent = 0;
  bit   quiet_tail = 1'b0;
  bit   hold_sender = 1'b0;
  bit   stim_done = 1'b0;

  function automatic logic [31:0] clamp64(input longint v);
    if (v > 64'sh7FFFFFFF) return 32'h7FFFFFFF;
    if (v < -64'sh80000000) return 32'h80000000;
    return v[31:0];
  endfunction

  function automatic logic [31:0] fix_mul(input logic [31:0] x, input logic [31:0] y);
    longint p;
    p = longint'($signed(x)) * longint'($signed(y));
    return clamp64(p >>> 16);  // arithmetic shift floors
  endfunction

  function automatic logic [31:0] fix_sqrt(input logic [31:0] x);
    longint s;
    logic [63:0] n, root, b;
    s = longint'($signed(x));
    if (s < 0) s = -s;
    n = 64'(s) << 16;
    root = 0;
    b = 64'd1 << 48;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root[31:0];
  endfunction

  // Execute one instruction on the shadow state; returns 1 if it emits a result
  function automatic bit execute_instr(input in_t it, output out_t res);
    op_e op;
    int need, pushes;
    logic [31:0] x, y;
    op = op_e'(it.op);
    res = '0;
    need = 0;
    pushes = 0;
    if (op == OP_ILL) begin
      shadow_depth = 0;
      res.status = ST_ILLEGAL;
      return 1;
    end
    case (op)
      OP_RET, OP_STX, OP_STA, OP_STB, OP_NEG, OP_SQR, OP_SQRT: need = 1;
      OP_ADD, OP_SUB, OP_MUL: need = 2;
      OP_DUP: begin need = 1; pushes = 1; end
      default: pushes = 1;
    endcase
    if (shadow_depth < need) begin
      shadow_depth = 0;
      res.status = ST_UNDER;
      return 1;
    end
    if (pushes != 0 && shadow_depth >= StackDepth) begin
      shadow_depth = 0;
      res.status = ST_OVER;
      return 1;
    end
    x = 0;
    y = 0;
    if (need == 2) begin
      y = shadow_stack[shadow_depth-1];
      x = shadow_stack[shadow_depth-2];
      shadow_depth -= 2;
    end else if (need == 1) begin
      x = shadow_stack[shadow_depth-1];
      shadow_depth -= 1;
    end
    case (op)
      OP_RET: begin
        shadow_depth = 0;
        res.value = x;
        res.status = ST_OK;
        return 1;
      end
      OP_LDX: shadow_stack[shadow_depth++] = (it.var_index < NumVars) ?
                shadow_vars[it.var_index] : 32'd0;
      OP_STX: if (it.var_index < NumVars) shadow_vars[it.var_index] = x;
      OP_LDA: shadow_stack[shadow_depth++] = shadow_a;
      OP_STA: shadow_a = x;
      OP_LDB: shadow_stack[shadow_depth++] = shadow_b;
      OP_STB: shadow_b = x;
      OP_ADD: shadow_stack[shadow_depth++] =
                clamp64(longint'($signed(x)) + longint'($signed(y)));
      OP_SUB: shadow_stack[shadow_depth++] =
                clamp64(longint'($signed(x)) - longint'($signed(y)));
      OP_NEG: shadow_stack[shadow_depth++] = clamp64(-longint'($signed(x)));
      OP_MUL: shadow_stack[shadow_depth++] = fix_mul(x, y);
      OP_SQR: shadow_stack[shadow_depth++] = fix_mul(x, x);
      OP_SQRT: shadow_stack[shadow_depth++] = fix_sqrt(x);
      OP_NUM: shadow_stack[shadow_depth++] = it.immediate;
      default: begin
        shadow_stack[shadow_depth++] = x;
        shadow_stack[shadow_depth++] = x;
      end
    endcase
    return 0;
  endfunction

  function automatic logic [31:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'($signed($urandom_range(0, 'h60000)) - 'h30000);
      3: return 32'h00010000 * $urandom_range(0, 4);
      default: return $urandom;
    endcase
  endfunction

  function automatic in_t make_instr(input op_e op, input logic [31:0] imm = 0,
                                     input logic [1:0] idx = 0);
    in_t it;
    it.op = op;
    it.var_index = idx;
    it.immediate = imm;
    return it;
  endfunction

  // Random well-formed expression built from a few leaf pushes, then ret
  task automatic queue_expression();
    int depth, steps, k;
    op_e op;
    depth = 0;
    steps = $urandom_range(2, 14);
    for (k = 0; k < steps; k++) begin
      if (depth < 2 || (depth < 14 && $urandom_range(0, 2) == 0)) begin
        case ($urandom_range(0, 4))
          0: op = OP_LDX;
          1: op = OP_LDA;
          2: op = OP_LDB;
          3: op = OP_DUP;
          default: op = OP_NUM;
        endcase
        if (op == OP_DUP && depth == 0) op = OP_NUM;
        pending_instr.push_back(make_instr(op, rand_q(), 2'($urandom)));
        depth += (op == OP_DUP) ? 1 : 1;
      end else begin
        case ($urandom_range(0, 9))
          0: op = OP_ADD; 1: op = OP_SUB; 2: op = OP_MUL;
          3: op = OP_NEG; 4: op = OP_SQR; 5: op = OP_SQRT;
          6: op = OP_STX; 7: op = OP_STA; 8: op = OP_STB;
          default: op = OP_ADD;
        endcase
        pending_instr.push_back(make_instr(op, $urandom, 2'($urandom)));
        if (op == OP_ADD || op == OP_SUB || op == OP_MUL) depth -= 1;
        if (op == OP_STX || op == OP_STA || op == OP_STB) depth -= 1;
      end
    end
    pending_instr.push_back(make_instr(OP_RET));
  endtask

  // Driver: feeds pending instructions, with random idle bursts
  int in_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) instr_sent++;
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap > 0) begin
          in_gap <= in_gap - 1;
          in_valid_i <= 1'b0;
        end else if (pending_instr.size() > 0 && !hold_sender) begin
          in_data_i <= pending_instr.pop_front();
          in_valid_i <= 1'b1;
          if (!quiet_tail && $urandom_range(0, 9) == 0) in_gap <= $urandom_range(1, 17);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Predict at the accepting edge
  always @(posedge clk_i) begin
    out_t r;
    if (rst_ni && in_valid_i && !in_stall_o)
      if (execute_instr(in_data_i, r)) expected_results.push_back(r);
  end

  // Receiver stall bursts
  int out_gap = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap <= out_gap - 1;
        out_stall_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
        out_gap <= $urandom_range(0, 16);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Monitor: compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin
    out_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result value=%h status=%0d", out_data_o.value,
               out_data_o.status);
        error_count++;
      end else begin
        e = expected_results.pop_front();
        if (out_data_o.value !== e.value) begin
          $error("value: expected %h actual %h", e.value, out_data_o.value);
          error_count++;
        end
        if (out_data_o.status !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, out_data_o.status);
          error_count++;
        end
      end
    end
  end

  initial begin
    int i, k;
    shadow_depth = 0;
    shadow_a = 0;
    shadow_b = 0;
    foreach (shadow_vars[i]) shadow_vars[i] = 0;
    foreach (shadow_stack[i]) shadow_stack[i] = 0;

    // Directed: extremes, every op, underflow, overflow, illegal
    pending_instr.push_back(make_instr(OP_RET));                // underflow empty
    pending_instr.push_back(make_instr(OP_NUM, 32'h7FFFFFFF));
    pending_instr.push_back(make_instr(OP_NUM, 32'h7FFFFFFF));
    pending_instr.push_back(make_instr(OP_ADD));                // saturate high
    pending_instr.push_back(make_instr(OP_NUM, 32'h80000000));
    pending_instr.push_back(make_instr(OP_NEG));                // neg of min
    pending_instr.push_back(make_instr(OP_SUB));                // second minus top
    pending_instr.push_back(make_instr(OP_STX, 0, 2'd3));
    pending_instr.push_back(make_instr(OP_LDX, 0, 2'd3));
    pending_instr.push_back(make_instr(OP_NUM, 32'h80000000));
    pending_instr.push_back(make_instr(OP_SQRT));               // root of min
    pending_instr.push_back(make_instr(OP_MUL));
    pending_instr.push_back(make_instr(OP_STA));
    pending_instr.push_back(make_instr(OP_NUM, 32'hFFFF8000));
    pending_instr.push_back(make_instr(OP_SQR));
    pending_instr.push_back(make_instr(OP_STB));
    pending_instr.push_back(make_instr(OP_LDA));
    pending_instr.push_back(make_instr(OP_LDB));
    pending_instr.push_back(make_instr(OP_ADD));
    pending_instr.push_back(make_instr(OP_RET));
    pending_instr.push_back(make_instr(OP_ADD));                // underflow two-op
    pending_instr.push_back(make_instr(OP_NUM, 32'h00010000));
    for (k = 0; k < 16; k++) pending_instr.push_back(make_instr(OP_DUP)); // overflow
    pending_instr.push_back(make_instr(OP_ILL, 32'hFFFFFFFF, 2'd3));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Random part: mostly well-formed expressions, some noise
    while (instr_sent + pending_instr.size() < 1700) begin
      if ($urandom_range(0, 9) < 8) queue_expression();
      else for (k = 0; k < $urandom_range(1, 6); k++)
        pending_instr.push_back(make_instr(op_e'($urandom_range(0, 15)), $urandom,
                                           2'($urandom)));
      while (pending_instr.size() > 40) @(posedge clk_i);
    end

    // Drain fully once with the sender held off
    while (pending_instr.size() > 0) @(posedge clk_i);
    hold_sender = 1'b1;
    while (in_valid_i || expected_results.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    hold_sender = 1'b0;

    // Last part without idling
    quiet_tail = 1'b1;
    for (i = 0; i < 40; i++) queue_expression();
    while (pending_instr.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Ran %0d instructions through the evaluator, %0d results checked,",
             instr_sent, results_seen);
    $display("covering saturation, pop order, underflow, overflow and illegal ops.");
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
